/* hw/rtl/tf512_pkg.sv */
// shared types, constants and helpers for the threefish-512 cipher pipeline
// rotation table, word permutation and key schedule constants
// no dependencies
`default_nettype none

package tf512_pkg;

    localparam int TF_WORDS    = 8;
    localparam int TF_NKEY     = TF_WORDS + 1;
    localparam int TF_ROUNDS   = 72;
    localparam int TF_SUBKEYS  = TF_ROUNDS / 4 + 1;
    // one injection stage per subkey plus one stage per round
    localparam int TF_STAGES   = TF_ROUNDS + TF_SUBKEYS;
    localparam int TF_WORD_W   = 64;
    localparam int TF_IN_W     = (TF_WORDS + 2) * TF_WORD_W;
    localparam int TF_OUT_W    = TF_WORDS * TF_WORD_W;
    localparam int TF_CFG_IDX_W = 4;

    localparam logic [63:0] TF_C240 = 64'h1BD11BDAA9FC1A22;

    localparam logic TF_FUNC_ENC = 1'b0;
    localparam logic TF_FUNC_DEC = 1'b1;

    localparam int TF_ROT [8][4] = '{
        '{46, 36, 19, 37},
        '{33, 27, 14, 42},
        '{17, 49, 36, 39},
        '{44,  9, 54, 56},
        '{39, 30, 34, 24},
        '{13, 50, 10, 17},
        '{25, 29, 39, 43},
        '{ 8, 35, 56, 22}
    };

    // word k after the mix layer lands at position TF_PERM[k]
    localparam int TF_PERM [8] = '{6, 1, 0, 7, 2, 5, 4, 3};

    typedef logic [TF_WORD_W-1:0] tf_word_t;

    typedef struct packed {
        logic                      func;
        tf_word_t                  tweak_high;
        tf_word_t                  tweak_low;
        logic [TF_WORDS-1:0][TF_WORD_W-1:0] words;
    } tf_pipe_t;

    function automatic tf_word_t tf_rol(input tf_word_t x, input int n);
        return (x << n) | (x >> (TF_WORD_W - n));
    endfunction

    function automatic tf_word_t tf_ror(input tf_word_t x, input int n);
        return (x >> n) | (x << (TF_WORD_W - n));
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tf512_stage.sv */
// one registered step of the threefish-512 pipeline: a subkey injection or a round
// encrypt and decrypt share the stage; decrypt runs the mirrored step
// depends on tf512_pkg
`default_nettype none

module tf512_stage #(
    parameter int STAGE_IDX = 0
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         en,
    input  wire logic [tf512_pkg::TF_NKEY-1:0][tf512_pkg::TF_WORD_W-1:0] kx,
    input  wire logic                                         in_valid,
    input  wire tf512_pkg::tf_pipe_t                          in_data,
    output logic                                              out_valid,
    output tf512_pkg::tf_pipe_t                               out_data
);
    import tf512_pkg::*;

    localparam bit IS_INJ = (STAGE_IDX % 5) == 0;
    localparam int SE     = STAGE_IDX / 5;
    localparam int SD     = TF_SUBKEYS - 1 - SE;
    localparam int DE     = IS_INJ ? 0 : 4 * SE + (STAGE_IDX % 5) - 1;
    localparam int DD     = TF_ROUNDS - 1 - DE;
    localparam int RE     = DE % 8;
    localparam int RD     = DD % 8;

    logic                               valid_reg;
    tf_pipe_t                           data_reg;
    logic [TF_WORDS-1:0][TF_WORD_W-1:0] words_next;
    logic                               dec;

    assign dec = (in_data.func == TF_FUNC_DEC);

    generate
        if (IS_INJ)
        begin : g_inject
            // decrypt subtracts: w - k - t == w + ~k + ~t + 2
            always_comb
            begin
                logic [2:0][TF_WORD_W-1:0] tx;
                tf_word_t k;
                tf_word_t t;
                tx[0] = in_data.tweak_low;
                tx[1] = in_data.tweak_high;
                tx[2] = in_data.tweak_low ^ in_data.tweak_high;
                for (int i = 0; i < TF_WORDS; i++)
                begin
                    k = dec ? kx[(SD + i) % TF_NKEY] : kx[(SE + i) % TF_NKEY];
                    if (i == 5)
                        t = dec ? tx[SD % 3] : tx[SE % 3];
                    else if (i == 6)
                        t = dec ? tx[(SD + 1) % 3] : tx[(SE + 1) % 3];
                    else if (i == 7)
                        t = dec ? TF_WORD_W'(SD) : TF_WORD_W'(SE);
                    else
                        t = '0;
                    words_next[i] = in_data.words[i] + (dec ? ~k : k) + (dec ? ~t : t)
                                    + (dec ? TF_WORD_W'(2) : TF_WORD_W'(0));
                end
            end
        end
        else
        begin : g_round
            always_comb
            begin
                logic [TF_WORDS-1:0][TF_WORD_W-1:0] enc_w;
                logic [TF_WORDS-1:0][TF_WORD_W-1:0] dec_w;
                tf_word_t es0;
                tf_word_t ds0;
                tf_word_t ds1;
                tf_word_t db;
                enc_w = '0;
                dec_w = '0;
                for (int j = 0; j < 4; j++)
                begin
                    es0 = in_data.words[2*j] + in_data.words[2*j+1];
                    enc_w[TF_PERM[2*j]]   = es0;
                    enc_w[TF_PERM[2*j+1]] = tf_rol(in_data.words[2*j+1], TF_ROT[RE][j]) ^ es0;

                    ds0 = in_data.words[TF_PERM[2*j]];
                    ds1 = in_data.words[TF_PERM[2*j+1]];
                    db  = tf_ror(ds0 ^ ds1, TF_ROT[RD][j]);
                    dec_w[2*j]   = ds0 - db;
                    dec_w[2*j+1] = db;
                end
                words_next = dec ? dec_w : enc_w;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg.func       <= in_data.func;
            data_reg.tweak_low  <= in_data.tweak_low;
            data_reg.tweak_high <= in_data.tweak_high;
            data_reg.words      <= words_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/threefish512_block_cipher.sv */
// threefish-512 tweakable block cipher, fully unrolled pipeline
// depends on tf512_pkg and tf512_stage
`default_nettype none

// Takes one 512-bit block per cycle with its 128-bit tweak and an encrypt or
// decrypt flag on tuser, and passes each block through an input
// register, 91 pipeline stages (72 round stages and 19 subkey injection stages,
// each a single add/rotate/xor or add step) and an output register. Throughput
// is one block per clock while the sink keeps up; a two-entry output buffer lets
// one more result land while the sink stalls, after which the whole pipe holds.
// The key words are read live by every injection stage, so write them only
// while no block is in flight. Writes to register indexes above 7 are ignored.
module threefish512_block_cipher (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // s_tdata: block_word_0..7, tweak_low, tweak_high (64 bits each)
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    input  wire logic [tf512_pkg::TF_IN_W-1:0]           s_tdata,
    // s_tuser: func
    input  wire logic                                    s_tuser,
    // m_tdata: result_word_0..7 (64 bits each)
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    output logic [tf512_pkg::TF_OUT_W-1:0]               m_tdata,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [tf512_pkg::TF_CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tf512_pkg::TF_WORD_W-1:0]         cfg_data
);
    import tf512_pkg::*;

    logic [TF_WORDS-1:0][TF_WORD_W-1:0] key_reg;
    logic [TF_NKEY-1:0][TF_WORD_W-1:0]  kx;

    logic                               en;
    logic                               in_valid_reg;
    tf_pipe_t                           in_data_reg;
    logic [TF_STAGES:0]                 pv;
    tf_pipe_t                           pd [TF_STAGES+1];

    logic                               out_valid_reg;
    logic [TF_OUT_W-1:0]                out_data_reg;
    logic                               skid_valid_reg;
    logic [TF_OUT_W-1:0]                skid_data_reg;
    logic                               push;
    logic                               out_free;

    // key registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= '0;
        else if (cfg_valid && cfg_ready && (cfg_index < TF_CFG_IDX_W'(TF_WORDS)))
            key_reg[cfg_index[$clog2(TF_WORDS)-1:0]] <= cfg_data;
    end

    always_comb
    begin
        kx[TF_WORDS] = TF_C240;
        for (int i = 0; i < TF_WORDS; i++)
        begin
            kx[i]        = key_reg[i];
            kx[TF_WORDS] = kx[TF_WORDS] ^ key_reg[i];
        end
    end

    // the pipe moves as one while the overflow slot is empty
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (en)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_data_reg.func       <= s_tuser;
            in_data_reg.words      <= s_tdata[TF_OUT_W-1:0];
            in_data_reg.tweak_low  <= s_tdata[TF_OUT_W +: TF_WORD_W];
            in_data_reg.tweak_high <= s_tdata[TF_OUT_W + TF_WORD_W +: TF_WORD_W];
        end
    end

    assign pv[0] = in_valid_reg;
    assign pd[0] = in_data_reg;

    generate
        for (genvar g = 0; g < TF_STAGES; g++)
        begin : g_stage
            tf512_stage #(
                .STAGE_IDX (g)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .kx        (kx),
                .in_valid  (pv[g]),
                .in_data   (pd[g]),
                .out_valid (pv[g+1]),
                .out_data  (pd[g+1])
            );
        end
    endgenerate

    // output register with one overflow slot
    assign push     = en && pv[TF_STAGES];
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_free)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_free)
                out_data_reg <= pd[TF_STAGES].words;
            else
                skid_data_reg <= pd[TF_STAGES].words;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("overflow slot holds a result while output register is empty");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !s_tready)
        else $error("input taken while overflow slot is full");

    a_input_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted transfer missing from input register");

    a_overflow_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !out_free) |=> (skid_valid_reg && out_valid_reg))
        else $error("result leaving the pipe was dropped");

endmodule

`default_nettype wire
